// ===== rtl/core/sspf_pkg.sv =====
// Package for the soft-sphere pair force pipeline.
// Holds payload structs, pipeline stage map, register reset values and step functions.
// No dependencies.
package sspf_pkg;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic        [23:0] first_radius;
    logic        [23:0] second_radius;
  } in_t;

  typedef struct packed {
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic        [30:0] pair_energy;
    logic signed [31:0] stress_xx;
    logic signed [31:0] stress_xy;
    logic signed [31:0] stress_yy;
    logic               overlapping;
  } out_t;

  typedef enum logic [1:0] {
    CfgBoxLength     = 2'd0,
    CfgBoxReciprocal = 2'd1,
    CfgTiltOffset    = 2'd2,
    CfgEnergyScale   = 2'd3
  } cfg_idx_e;

  localparam logic [30:0] BoxLengthRst    = 31'd3435479;
  localparam logic [31:0] BoxReciprocalRst = 32'd81931700;
  localparam logic [31:0] TiltOffsetRst   = 32'd0;
  localparam logic [30:0] EnergyScaleRst  = 31'd65536;

  // stage map of the iterative section
  localparam int unsigned SqSteps    = 25;
  localparam int unsigned VhSteps    = 17;
  localparam int unsigned CSteps     = 33;
  localparam int unsigned ASteps     = 48;
  localparam int unsigned KDivInit   = SqSteps;
  localparam int unsigned KDiv0      = KDivInit + 1;
  localparam int unsigned KMul       = KDiv0 + VhSteps;
  localparam int unsigned KEnergy    = KMul + 1;
  localparam int unsigned KA0        = KEnergy + 1;
  localparam int unsigned PipeStages = KA0 + ASteps;
  localparam int unsigned FrontStages = 12;
  localparam int unsigned TailStages = 5;
  localparam int unsigned Latency    = FrontStages + PipeStages + TailStages;

  typedef struct packed {
    logic        ovl;
    logic        rzero;
    logic        dx_pos;
    logic        dy_pos;
    logic        sxy_neg;
    logic [24:0] ax;
    logic [24:0] ay;
    logic [24:0] sigma;
    logic [49:0] sq_rem;
    logic [24:0] root;
    logic [24:0] vh_rem;
    logic [16:0] vh_sh;
    logic [24:0] cx_rem;
    logic [32:0] cx_sh;
    logic [24:0] cy_rem;
    logic [32:0] cy_sh;
    logic [24:0] a_rem;
    logic [47:0] a_sh;
    logic [32:0] vsq;
    logic [30:0] energy;
  } pipe_t;

  typedef struct packed {
    logic        ovl;
    logic        rzero;
    logic        dx_pos;
    logic        dy_pos;
    logic        sxy_neg;
    logic [24:0] ax;
    logic [24:0] ay;
    logic [30:0] energy;
  } tail_t;

  // one root bit: returns {remainder, root}
  function automatic logic [74:0] sqrt_step(logic [49:0] rem, logic [24:0] root,
                                            int unsigned b);
    logic [50:0] trial;
    logic [74:0] res;
    trial = (51'(root) << (b + 1)) | (51'(1) << (2 * b));
    if (51'(rem) >= trial) begin
      res = {50'(51'(rem) - trial), root | (25'(1) << b)};
    end else begin
      res = {rem, root};
    end
    return res;
  endfunction

  // one quotient bit: returns {quotient bit, remainder}
  function automatic logic [25:0] div_step(logic [24:0] rem, logic b, logic [24:0] den);
    logic [25:0] t;
    logic [25:0] res;
    t = {rem, b};
    if (t >= {1'b0, den}) begin
      res = {1'b1, 25'(t - {1'b0, den})};
    end else begin
      res = {1'b0, t[24:0]};
    end
    return res;
  endfunction

  function automatic logic [31:0] sat32(logic [59:0] m, logic neg);
    logic [59:0] c;
    logic [31:0] res;
    if (neg) begin
      c = (m > 60'h0_0000_0080_0000_00) ? 60'h0_0000_0080_0000_00 : m;
      res = 32'(~c[31:0] + 32'd1);
    end else begin
      c = (m > 60'h0_0000_007F_FFFF_FF) ? 60'h0_0000_007F_FFFF_FF : m;
      res = c[31:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/soft_sphere_pair_force.sv =====
// Soft-sphere pair force, top level. Throughput: one transaction per cycle while
// the output is not stalled; the 25-stage square root, the 17-stage overlap divider
// and the 48-stage force-amplitude divider set most of the depth.
// A stalled output freezes the whole pipeline. Reset clears all valid bits and
// loads the register defaults. Depends on sspf_pkg.
module soft_sphere_pair_force (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sspf_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sspf_pkg::out_t   out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  localparam int unsigned NSt = sspf_pkg::PipeStages;
  localparam int unsigned Lat = sspf_pkg::Latency;

  logic en;
  logic [Lat-1:0] vld_q;

  logic [30:0]        box_len_q;
  logic [31:0]        box_rcp_q;
  logic signed [31:0] tilt_q;
  logic [30:0]        eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_len_q <= sspf_pkg::BoxLengthRst;
      box_rcp_q <= sspf_pkg::BoxReciprocalRst;
      tilt_q    <= sspf_pkg::TiltOffsetRst;
      eps_q     <= sspf_pkg::EnergyScaleRst;
    end else if (cfg_we_i) begin
      unique case (sspf_pkg::cfg_idx_e'(cfg_index_i))
        sspf_pkg::CfgBoxLength:     box_len_q <= cfg_data_i[30:0];
        sspf_pkg::CfgBoxReciprocal: box_rcp_q <= cfg_data_i;
        sspf_pkg::CfgTiltOffset:    tilt_q    <= cfg_data_i;
        sspf_pkg::CfgEnergyScale:   eps_q     <= cfg_data_i[30:0];
      endcase
    end
  end

  assign en          = !vld_q[Lat-1] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // ---------------- minimum image ----------------
  logic signed [32:0] dx1_q, dx2_q, dx3_q, dx4_q;
  logic signed [32:0] dy1_q, dy2_q, dy3_q, dy4_q;
  logic [24:0] sg1_q, sg2_q, sg3_q, sg4_q, sg5_q, sg6_q, sg7_q, sg8_q, sg9_q, sg10_q;
  logic [24:0] sg11_q, sg12_q;
  logic [32:0] ady2_d;
  logic [64:0] py2_q;
  logic [18:0] nt3_d;
  logic signed [18:0] ny3_q;
  logic [17:0] nym3_q;
  logic signed [50:0] pt4_q;
  logic [48:0] ly4_q;
  logic signed [50:0] dxp5_q, dxp6_q, dxp7_q, dxp8_q;
  logic signed [50:0] dyf5_q, dyf6_q, dyf7_q, dyf8_q, dyf9_q;
  logic [50:0] adx6_d;
  logic [50:0] phi6_q;
  logic [63:0] plo6_q;
  logic [51:0] s7_d;
  logic [37:0] nt7_d;
  logic [31:0] nxm7_q;
  logic [62:0] lx8_q;
  logic signed [63:0] dxf9_q, dyf9w_d;
  logic [63:0] adx10_d, ady10_d;
  logic [24:0] ax10_q, ay10_q, ax11_q, ay11_q, ax12_q, ay12_q;
  logic far10_q, far11_q;
  logic [2:0] sgn10_q, sgn11_q, sgn12_q;
  logic [49:0] x211_q, y211_q, s211_q;
  logic [50:0] d212_d;
  logic [49:0] d212_q;
  logic ovl12_q;

  always_comb begin
    ady2_d  = dy1_q[32] ? 33'(-dy1_q) : 33'(dy1_q);
    nt3_d   = 19'(py2_q[64:47]) + 19'd1;
    adx6_d  = dxp5_q[50] ? 51'(-dxp5_q) : 51'(dxp5_q);
    s7_d    = 52'(phi6_q) + 52'(plo6_q[63:32]);
    nt7_d   = 38'(s7_d[51:15]) + 38'd1;
    dyf9w_d = 64'(dyf9_q);
    adx10_d = dxf9_q[63] ? 64'(-dxf9_q) : 64'(dxf9_q);
    ady10_d = dyf9w_d[63] ? 64'(-dyf9w_d) : 64'(dyf9w_d);
    d212_d  = 51'(x211_q) + 51'(y211_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q  <= 33'(in_data_i.first_x) - 33'(in_data_i.second_x);
      dy1_q  <= 33'(in_data_i.first_y) - 33'(in_data_i.second_y);
      sg1_q  <= 25'(in_data_i.first_radius) + 25'(in_data_i.second_radius);

      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      sg2_q  <= sg1_q;
      py2_q  <= 65'(ady2_d) * 65'(box_rcp_q);

      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
      sg3_q  <= sg2_q;
      nym3_q <= nt3_d[18:1];
      ny3_q  <= dy2_q[32] ? -19'(nt3_d[18:1]) : 19'(nt3_d[18:1]);

      dx4_q  <= dx3_q;
      dy4_q  <= dy3_q;
      sg4_q  <= sg3_q;
      pt4_q  <= 51'(tilt_q) * 51'(ny3_q);
      ly4_q  <= 49'(box_len_q) * 49'(nym3_q);

      dxp5_q <= 51'(dx4_q) - pt4_q;
      dyf5_q <= dy4_q[32] ? 51'(dy4_q) + 51'(ly4_q) : 51'(dy4_q) - 51'(ly4_q);
      sg5_q  <= sg4_q;

      dxp6_q <= dxp5_q;
      dyf6_q <= dyf5_q;
      sg6_q  <= sg5_q;
      phi6_q <= 51'(adx6_d[50:32]) * 51'(box_rcp_q);
      plo6_q <= 64'(adx6_d[31:0]) * 64'(box_rcp_q);

      dxp7_q <= dxp6_q;
      dyf7_q <= dyf6_q;
      sg7_q  <= sg6_q;
      nxm7_q <= (nt7_d[37:1] > 37'h0_8000_0000) ? 32'h8000_0000 : nt7_d[32:1];

      dxp8_q <= dxp7_q;
      dyf8_q <= dyf7_q;
      sg8_q  <= sg7_q;
      lx8_q  <= 63'(box_len_q) * 63'(nxm7_q);

      dxf9_q <= dxp8_q[50] ? 64'(dxp8_q) + 64'(lx8_q) : 64'(dxp8_q) - 64'(lx8_q);
      dyf9_q <= dyf8_q;
      sg9_q  <= sg8_q;

      ax10_q  <= adx10_d[24:0];
      ay10_q  <= ady10_d[24:0];
      far10_q <= (|adx10_d[63:25]) || (|ady10_d[63:25]);
      sgn10_q <= {!dxf9_q[63] && (dxf9_q != '0),
                  !dyf9_q[50] && (dyf9_q != '0),
                  (dxf9_q != '0) && (dyf9_q != '0) && (dxf9_q[63] == dyf9_q[50])};
      sg10_q  <= sg9_q;

      x211_q  <= 50'(ax10_q) * 50'(ax10_q);
      y211_q  <= 50'(ay10_q) * 50'(ay10_q);
      s211_q  <= 50'(sg10_q) * 50'(sg10_q);
      ax11_q  <= ax10_q;
      ay11_q  <= ay10_q;
      far11_q <= far10_q;
      sgn11_q <= sgn10_q;
      sg11_q  <= sg10_q;

      d212_q  <= d212_d[49:0];
      ovl12_q <= !far11_q && (d212_d < 51'(s211_q));
      ax12_q  <= ax11_q;
      ay12_q  <= ay11_q;
      sgn12_q <= sgn11_q;
      sg12_q  <= sg11_q;
    end
  end

  // ---------------- root and dividers ----------------
  sspf_pkg::pipe_t head_d;
  sspf_pkg::pipe_t pipe_q [NSt];

  always_comb begin
    head_d         = '0;
    head_d.ovl     = ovl12_q;
    head_d.dx_pos  = sgn12_q[2];
    head_d.dy_pos  = sgn12_q[1];
    head_d.sxy_neg = sgn12_q[0];
    head_d.ax      = ax12_q;
    head_d.ay      = ay12_q;
    head_d.sigma   = sg12_q;
    head_d.sq_rem  = d212_q;
  end

  for (genvar k = 0; k < NSt; k++) begin : g_st
    localparam int unsigned Bit = (k < sspf_pkg::SqSteps) ? sspf_pkg::SqSteps - 1 - k : 0;
    sspf_pkg::pipe_t prv;
    sspf_pkg::pipe_t nxt;

    if (k == 0) begin : g_head
      assign prv = head_d;
    end else begin : g_body
      assign prv = pipe_q[k-1];
    end

    always_comb begin
      logic [25:0] qx;
      logic [25:0] qy;
      logic [25:0] qv;
      logic [25:0] qa;
      logic [24:0] diff;
      nxt  = prv;
      qx   = '0;
      qy   = '0;
      qv   = '0;
      qa   = '0;
      diff = prv.sigma - prv.root;
      if (k < sspf_pkg::SqSteps) begin
        {nxt.sq_rem, nxt.root} = sspf_pkg::sqrt_step(prv.sq_rem, prv.root, Bit);
      end
      if (k == sspf_pkg::KDivInit) begin
        nxt.rzero  = (prv.root == '0);
        nxt.vh_rem = {1'b0, diff[24:1]};
        nxt.vh_sh  = {diff[0], 16'b0};
        nxt.cx_rem = {1'b0, prv.ax[24:1]};
        nxt.cx_sh  = {prv.ax[0], 32'b0};
        nxt.cy_rem = {1'b0, prv.ay[24:1]};
        nxt.cy_sh  = {prv.ay[0], 32'b0};
      end
      if (k >= sspf_pkg::KDiv0 && k < sspf_pkg::KDiv0 + sspf_pkg::CSteps) begin
        qx         = sspf_pkg::div_step(prv.cx_rem, prv.cx_sh[32], prv.root);
        qy         = sspf_pkg::div_step(prv.cy_rem, prv.cy_sh[32], prv.root);
        nxt.cx_rem = qx[24:0];
        nxt.cx_sh  = {prv.cx_sh[31:0], qx[25]};
        nxt.cy_rem = qy[24:0];
        nxt.cy_sh  = {prv.cy_sh[31:0], qy[25]};
      end
      if (k >= sspf_pkg::KDiv0 && k < sspf_pkg::KMul) begin
        qv         = sspf_pkg::div_step(prv.vh_rem, prv.vh_sh[16], prv.sigma);
        nxt.vh_rem = qv[24:0];
        nxt.vh_sh  = {prv.vh_sh[15:0], qv[25]};
      end
      if (k == sspf_pkg::KMul) begin
        nxt.a_sh  = (48'(eps_q) * 48'(prv.vh_sh)) << 1;
        nxt.a_rem = '0;
        nxt.vsq   = 33'(prv.vh_sh) * 33'(prv.vh_sh);
      end
      if (k == sspf_pkg::KEnergy) begin
        nxt.energy = 31'((64'(eps_q) * 64'(prv.vsq)) >> 32);
      end
      if (k >= sspf_pkg::KA0) begin
        qa        = sspf_pkg::div_step(prv.a_rem, prv.a_sh[47], prv.sigma);
        nxt.a_rem = qa[24:0];
        nxt.a_sh  = {prv.a_sh[46:0], qa[25]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pipe_q[k] <= nxt;
      end
    end
  end

  // ---------------- force and stress products ----------------
  sspf_pkg::pipe_t pl;
  sspf_pkg::tail_t tl0_d, tl1_q, tl2_q, tl3_q, tl4_q;
  logic [48:0] phx1_q, phy1_q;
  logic [64:0] plx1_q, ply1_q;
  logic [49:0] gx2_q, gy2_q;
  logic [50:0] sxxh3_q, sxyh3_q, syyh3_q;
  logic [48:0] sxxl3_q, sxyl3_q, syyl3_q;
  logic [31:0] gsx3_q, gsy3_q, gsx4_q, gsy4_q;
  logic [59:0] sxx4_q, sxy4_q, syy4_q;
  logic mask4_d;
  sspf_pkg::out_t out_d, out_q;

  assign pl = pipe_q[NSt-1];

  always_comb begin
    tl0_d.ovl     = pl.ovl;
    tl0_d.rzero   = pl.rzero;
    tl0_d.dx_pos  = pl.dx_pos;
    tl0_d.dy_pos  = pl.dy_pos;
    tl0_d.sxy_neg = pl.sxy_neg;
    tl0_d.ax      = pl.ax;
    tl0_d.ay      = pl.ay;
    tl0_d.energy  = pl.energy;
  end

  always_comb begin
    mask4_d               = tl4_q.ovl && !tl4_q.rzero;
    out_d.overlapping     = tl4_q.ovl;
    out_d.pair_energy     = tl4_q.ovl ? tl4_q.energy : '0;
    out_d.grad_x          = mask4_d ? gsx4_q : '0;
    out_d.grad_y          = mask4_d ? gsy4_q : '0;
    out_d.stress_xx       = mask4_d ? sspf_pkg::sat32(sxx4_q, tl4_q.ax != '0) : '0;
    out_d.stress_xy       = mask4_d ? sspf_pkg::sat32(sxy4_q, tl4_q.sxy_neg) : '0;
    out_d.stress_yy       = mask4_d ? sspf_pkg::sat32(syy4_q, tl4_q.ay != '0) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phx1_q  <= 49'(pl.a_sh[47:32]) * 49'(pl.cx_sh);
      plx1_q  <= 65'(pl.a_sh[31:0]) * 65'(pl.cx_sh);
      phy1_q  <= 49'(pl.a_sh[47:32]) * 49'(pl.cy_sh);
      ply1_q  <= 65'(pl.a_sh[31:0]) * 65'(pl.cy_sh);
      tl1_q   <= tl0_d;

      gx2_q   <= 50'(phx1_q) + 50'(plx1_q[64:32]);
      gy2_q   <= 50'(phy1_q) + 50'(ply1_q[64:32]);
      tl2_q   <= tl1_q;

      sxxh3_q <= 51'(gx2_q[49:24]) * 51'(tl2_q.ax);
      sxxl3_q <= 49'(gx2_q[23:0]) * 49'(tl2_q.ax);
      sxyh3_q <= 51'(gx2_q[49:24]) * 51'(tl2_q.ay);
      sxyl3_q <= 49'(gx2_q[23:0]) * 49'(tl2_q.ay);
      syyh3_q <= 51'(gy2_q[49:24]) * 51'(tl2_q.ay);
      syyl3_q <= 49'(gy2_q[23:0]) * 49'(tl2_q.ay);
      gsx3_q  <= sspf_pkg::sat32(60'(gx2_q), tl2_q.dx_pos);
      gsy3_q  <= sspf_pkg::sat32(60'(gy2_q), tl2_q.dy_pos);
      tl3_q   <= tl2_q;

      sxx4_q  <= (60'(sxxh3_q) << 8) + 60'(sxxl3_q[48:16]);
      sxy4_q  <= (60'(sxyh3_q) << 8) + 60'(sxyl3_q[48:16]);
      syy4_q  <= (60'(syyh3_q) << 8) + 60'(syyl3_q[48:16]);
      gsx4_q  <= gsx3_q;
      gsy4_q  <= gsy3_q;
      tl4_q   <= tl3_q;

      out_q   <= out_d;
    end
  end

  assign out_data_o = out_q;

  // ---------------- assertions ----------------
  a_stall_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output backpressure");

  a_no_overlap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.overlapping |->
      out_data_o.grad_x == '0 && out_data_o.grad_y == '0 &&
      out_data_o.pair_energy == '0 && out_data_o.stress_xx == '0 &&
      out_data_o.stress_xy == '0 && out_data_o.stress_yy == '0)
    else $error("non-overlapping transaction has nonzero results");

  a_energy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pair_energy <= eps_q)
    else $error("pair energy above energy scale");

  a_shift_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during stall");

endmodule
